/* sv/sobel_edge_magnitude_rgb_macros.svh */
// ----------------------------------------------------------------------------
// Sobel edge magnitude: assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

`ifndef SYNTHESIS

`define SEM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

`define SEM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define SEM_ASSERT_IMPL(name, ante, cons)

`define SEM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* sv/sem_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register indexes and pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CHAN_W;
    localparam int POS_W      = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int SOBEL_W    = 10;
    localparam int SQ_W       = 2 * CHAN_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    localparam int IMAGE_WIDTH_RST  = 640;
    localparam int IMAGE_HEIGHT_RST = 480;
    localparam int MIN_SIZE         = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [CHAN_W-1:0] chan_t;

    // channel 0 red, 1 green, 2 blue
    typedef chan_t [NUM_CH-1:0] pix_t;

    typedef struct packed {
        pix_t ax;
        pix_t ay;
    } grad_t;

    typedef struct packed {
        chan_t            alpha;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             eof;
    } meta_t;

    typedef struct packed {
        chan_t            root;
        logic [SUM_W-1:0] square;
        logic [SUM_W-1:0] target;
    } root_t;

endpackage

`default_nettype wire

/* sv/sem_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/sem_window.sv */
// ----------------------------------------------------------------------------
// Sobel window and gradient stage
// Raster counters, line store RAM, 3x3 window and per-channel |gx|, |gy|.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_window #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [WB-1:0]   width,
    input  wire logic [HB-1:0]   height,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sem_pkg::pix_t   in_pix,
    input  wire sem_pkg::chan_t  in_alpha,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sem_pkg::grad_t       out_grad,
    output sem_pkg::meta_t       out_meta
);

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_W = 2 * sem_pkg::PIX_W;
    localparam int SW     = sem_pkg::SOBEL_W;

    function automatic sem_pkg::chan_t abs_sat(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (d > SW'({sem_pkg::CHAN_W{1'b1}})) ? {sem_pkg::CHAN_W{1'b1}}
                                                 : d[sem_pkg::CHAN_W-1:0];
    endfunction

    logic           acc;
    logic           s1_fire;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [WB-1:0]  col_inc;
    logic [HB-1:0]  row_inc;
    logic           col_wrap;
    logic           row_wrap;
    logic           emit;
    sem_pkg::meta_t meta_in;

    logic           v1_reg;
    logic           emit1_reg;
    sem_pkg::pix_t  pix1_reg;
    logic [CW-1:0]  addr1_reg;
    sem_pkg::meta_t meta1_reg;

    logic [LINE_W-1:0] rd_data;
    sem_pkg::pix_t     top_pix;
    sem_pkg::pix_t     mid_pix;
    sem_pkg::pix_t     wa_reg [3];
    sem_pkg::pix_t     wb_reg [3];

    sem_pkg::chan_t ax_next [sem_pkg::NUM_CH];
    sem_pkg::chan_t ay_next [sem_pkg::NUM_CH];
    sem_pkg::grad_t grad_next;

    logic           v2_reg;
    sem_pkg::grad_t grad2_reg;
    sem_pkg::meta_t meta2_reg;

    // raster position of the incoming pixel
    assign col_inc  = WB'(col_reg) + WB'(1);
    assign row_inc  = HB'(row_reg) + HB'(1);
    assign col_wrap = (col_inc >= width);
    assign row_wrap = (row_inc >= height);

    always_comb
    begin
        col_next = col_wrap ? '0 : CW'(col_inc);
        row_next = row_reg;
        if (col_wrap)
        begin
            row_next = row_wrap ? '0 : RW'(row_inc);
        end
    end

    assign emit = (col_reg >= CW'(2)) && (row_reg >= RW'(2))
               && (WB'(col_reg) < width) && (HB'(row_reg) < height);

    always_comb
    begin
        meta_in.alpha  = in_alpha;
        meta_in.column = sem_pkg::POS_W'(col_reg - CW'(1));
        meta_in.row    = sem_pkg::POS_W'(row_reg - RW'(1));
        meta_in.eof    = col_wrap && row_wrap;
    end

    assign s1_fire  = v1_reg && (!v2_reg || out_ready);
    assign in_ready = !v1_reg || s1_fire;
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (acc)
            begin
                v1_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            emit1_reg <= emit;
            pix1_reg  <= in_pix;
            addr1_reg <= col_reg;
            meta1_reg <= meta_in;
        end
    end

    // entry holds {older line, newer line}; write back {newer line, current}
    sem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (addr1_reg),
        .wr_data ({mid_pix, pix1_reg}),
        .rd_en   (acc),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    assign top_pix = rd_data[LINE_W-1:sem_pkg::PIX_W];
    assign mid_pix = rd_data[sem_pkg::PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                wa_reg[r] <= '0;
                wb_reg[r] <= '0;
            end
        end
        else if (s1_fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                wa_reg[r] <= wb_reg[r];
            end
            wb_reg[0] <= top_pix;
            wb_reg[1] <= mid_pix;
            wb_reg[2] <= pix1_reg;
        end
    end

    for (genvar c = 0; c < sem_pkg::NUM_CH; c++)
    begin : g_chan
        logic [SW-1:0] x_right;
        logic [SW-1:0] x_left;
        logic [SW-1:0] y_top;
        logic [SW-1:0] y_bot;

        assign x_right = SW'(top_pix[c]) + (SW'(mid_pix[c]) << 1) + SW'(pix1_reg[c]);
        assign x_left  = SW'(wa_reg[0][c]) + (SW'(wa_reg[1][c]) << 1) + SW'(wa_reg[2][c]);
        assign y_top   = SW'(wa_reg[0][c]) + (SW'(wb_reg[0][c]) << 1) + SW'(top_pix[c]);
        assign y_bot   = SW'(wa_reg[2][c]) + (SW'(wb_reg[2][c]) << 1) + SW'(pix1_reg[c]);
        assign ax_next[c] = abs_sat(x_right, x_left);
        assign ay_next[c] = abs_sat(y_top, y_bot);
    end

    always_comb
    begin
        for (int c = 0; c < sem_pkg::NUM_CH; c++)
        begin
            grad_next.ax[c] = ax_next[c];
            grad_next.ay[c] = ay_next[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            v2_reg <= emit1_reg;
        end
        else if (out_ready)
        begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            grad2_reg <= grad_next;
            meta2_reg <= meta1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_grad  = grad2_reg;
    assign out_meta  = meta2_reg;

endmodule

`default_nettype wire

/* sv/sem_mag.sv */
// ----------------------------------------------------------------------------
// Sobel magnitude pipeline
// Squares and sums |gx|, |gy|, then a bit-per-stage integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_mag (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sem_pkg::grad_t in_grad,
    input  wire sem_pkg::meta_t in_meta,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sem_pkg::pix_t       out_mag,
    output sem_pkg::meta_t      out_meta
);

    localparam int NS   = sem_pkg::CHAN_W;
    localparam int SUMW = sem_pkg::SUM_W;

    logic [NS:0]    v_reg;
    logic [NS:0]    load;
    sem_pkg::root_t rt_reg [NS+1][sem_pkg::NUM_CH];
    sem_pkg::meta_t meta_reg [NS+1];

    // a stage loads when empty or when the stage after it moves
    assign load[NS] = !v_reg[NS] || out_ready;
    for (genvar i = 0; i < NS; i++)
    begin : g_load
        assign load[i] = !v_reg[i] || load[i+1];
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i <= NS; i++)
            begin
                if (load[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    for (genvar c = 0; c < sem_pkg::NUM_CH; c++)
    begin : g_sq
        logic [sem_pkg::SQ_W-1:0] sq_x;
        logic [sem_pkg::SQ_W-1:0] sq_y;

        assign sq_x = sem_pkg::SQ_W'(in_grad.ax[c]) * sem_pkg::SQ_W'(in_grad.ax[c]);
        assign sq_y = sem_pkg::SQ_W'(in_grad.ay[c]) * sem_pkg::SQ_W'(in_grad.ay[c]);

        always_ff @(posedge clk)
        begin
            if (load[0])
            begin
                rt_reg[0][c].root   <= '0;
                rt_reg[0][c].square <= '0;
                rt_reg[0][c].target <= SUMW'(sq_x) + SUMW'(sq_y);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            meta_reg[0] <= in_meta;
        end
    end

    for (genvar i = 1; i <= NS; i++)
    begin : g_stage
        localparam int K = NS - i;

        for (genvar c = 0; c < sem_pkg::NUM_CH; c++)
        begin : g_ch
            logic [SUMW-1:0] cand;

            // (root + 2^K)^2 from root^2
            assign cand = rt_reg[i-1][c].square
                        + (SUMW'(rt_reg[i-1][c].root) << (K + 1))
                        + (SUMW'(1) << (2 * K));

            always_ff @(posedge clk)
            begin
                if (load[i])
                begin
                    if (cand <= rt_reg[i-1][c].target)
                    begin
                        rt_reg[i][c].root   <= rt_reg[i-1][c].root
                                             | (sem_pkg::CHAN_W'(1) << K);
                        rt_reg[i][c].square <= cand;
                    end
                    else
                    begin
                        rt_reg[i][c].root   <= rt_reg[i-1][c].root;
                        rt_reg[i][c].square <= rt_reg[i-1][c].square;
                    end
                    rt_reg[i][c].target <= rt_reg[i-1][c].target;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[i])
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < sem_pkg::NUM_CH; c++)
        begin
            out_mag[c] = rt_reg[NS][c].root;
        end
    end

    assign out_valid = v_reg[NS];
    assign out_meta  = meta_reg[NS];

endmodule

`default_nettype wire

/* sv/sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGBA
// 3x3 Sobel gradient magnitude per color channel over a raster pixel stream.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_axis    in   one raster pixel: red, green, blue, alpha
// m_axis    out  one interior pixel: three magnitudes, alpha, column, row;
//                tlast on the last interior pixel of the frame
// cfg       in   register write: image_width, image_height
//
// One pixel per cycle while the output is not stalled; the line store RAM is read at
// acceptance and written back when the pixel leaves the window stage, never to the
// column being read. m_axis_tvalid follows acceptance through the window, gradient,
// square and eight root stages. Reset clears counters, window and pipeline, not the
// line store. Each stage holds only when the stage after it is full, so
// s_axis_tready drops only once the whole pipeline is full behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sobel_edge_magnitude_rgb_macros.svh"

module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // red, green, blue, alpha
    input  wire logic [sem_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // red_magnitude, green_magnitude, blue_magnitude, alpha_out,
    // out_column, out_row, two zero pad bits
    output logic      [sem_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // end_of_frame
    output logic                                 m_axis_tlast
);

    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = $clog2(MAX_HEIGHT + 1);
    localparam int CM1  = (sem_pkg::CFG_W > WB) ? sem_pkg::CFG_W : WB;
    localparam int CMPW = (CM1 > HB) ? CM1 : HB;
    localparam int W_RST = (sem_pkg::IMAGE_WIDTH_RST > MAX_WIDTH)
                         ? MAX_WIDTH : sem_pkg::IMAGE_WIDTH_RST;
    localparam int H_RST = (sem_pkg::IMAGE_HEIGHT_RST > MAX_HEIGHT)
                         ? MAX_HEIGHT : sem_pkg::IMAGE_HEIGHT_RST;

    logic [WB-1:0]   width_reg;
    logic [WB-1:0]   width_next;
    logic [HB-1:0]   height_reg;
    logic [HB-1:0]   height_next;
    logic [CMPW-1:0] cfg_ext;

    sem_pkg::pix_t  in_pix;
    logic           grad_valid;
    logic           grad_ready;
    sem_pkg::grad_t grad;
    sem_pkg::meta_t grad_meta;
    sem_pkg::pix_t  mag;
    sem_pkg::meta_t out_meta;

    // clamp sizes as they are written
    assign cfg_ext = CMPW'(cfg_data);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        case (cfg_index)
            sem_pkg::REG_IMAGE_WIDTH:
            begin
                if (cfg_ext < CMPW'(sem_pkg::MIN_SIZE))
                    width_next = WB'(sem_pkg::MIN_SIZE);
                else if (cfg_ext > CMPW'(MAX_WIDTH))
                    width_next = WB'(MAX_WIDTH);
                else
                    width_next = WB'(cfg_ext);
            end
            sem_pkg::REG_IMAGE_HEIGHT:
            begin
                if (cfg_ext < CMPW'(sem_pkg::MIN_SIZE))
                    height_next = HB'(sem_pkg::MIN_SIZE);
                else if (cfg_ext > CMPW'(MAX_HEIGHT))
                    height_next = HB'(MAX_HEIGHT);
                else
                    height_next = HB'(cfg_ext);
            end
            default:
            begin
                width_next  = width_reg;
                height_next = height_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WB'(W_RST);
            height_reg <= HB'(H_RST);
        end
        else if (cfg_we)
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign in_pix[0] = s_axis_tdata[7:0];
    assign in_pix[1] = s_axis_tdata[15:8];
    assign in_pix[2] = s_axis_tdata[23:16];

    sem_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (width_reg),
        .height    (height_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .in_alpha  (s_axis_tdata[31:24]),
        .out_valid (grad_valid),
        .out_ready (grad_ready),
        .out_grad  (grad),
        .out_meta  (grad_meta)
    );

    sem_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grad_valid),
        .in_ready  (grad_ready),
        .in_grad   (grad),
        .in_meta   (grad_meta),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_mag   (mag),
        .out_meta  (out_meta)
    );

    assign m_axis_tdata = {2'b00, out_meta.row, out_meta.column, out_meta.alpha,
                           mag[2], mag[1], mag[0]};
    assign m_axis_tlast = out_meta.eof;

    `SEM_ASSERT_NEXT(a_size_clamped, cfg_we,
        (width_reg >= WB'(sem_pkg::MIN_SIZE)) && (width_reg <= WB'(MAX_WIDTH))
        && (height_reg >= HB'(sem_pkg::MIN_SIZE)) && (height_reg <= HB'(MAX_HEIGHT)))
    `SEM_ASSERT_NEXT(a_grad_hold, grad_valid && !grad_ready,
        grad_valid && $stable(grad_meta) && $stable(grad))
    `SEM_ASSERT_IMPL(a_mag_full_when_busy, !grad_ready, m_axis_tvalid && !m_axis_tready)

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams RGBA frames of several sizes through the block, with random gaps
// on the pixel input and random stalls on the result output. A local
// line-store and window model predicts every interior-pixel result, and each
// result beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_MAX       = 2048;
    localparam int FRAME_MAX      = 2048;
    localparam int IDLE_PCT       = 18;
    localparam int SETTLE_CYCLES  = 24;
    localparam int ITEM_TARGET    = 1150;
    localparam int DIRECTED_COUNT = 18;
    localparam longint TIMEOUT_NS = 10_000_000;

    typedef struct packed {
        sem_pkg::chan_t red;
        sem_pkg::chan_t green;
        sem_pkg::chan_t blue;
        sem_pkg::chan_t alpha;
    } pixel_t;

    typedef struct packed {
        sem_pkg::chan_t            red_mag;
        sem_pkg::chan_t            green_mag;
        sem_pkg::chan_t            blue_mag;
        sem_pkg::chan_t            alpha;
        logic [sem_pkg::POS_W-1:0] column;
        logic [sem_pkg::POS_W-1:0] row;
        logic                      eof;
    } edge_result_t;

    typedef struct packed {
        pixel_t       px;
        logic         typed;
        edge_result_t want;
    } stim_row_t;

    typedef enum int {
        PAT_NOISE,
        PAT_SMOOTH,
        PAT_RAILS,
        PAT_MIXED
    } pattern_t;

    localparam edge_result_t NO_EDGE = '0;

    // two 3x3 frames: flat white, then a red vertical step, a green
    // horizontal step and a lone blue center pixel
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h11}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h22}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h33}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h44}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h55}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h66}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h77}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'h88}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'h88, 11'd1, 11'd1, 1'b1}},
        '{'{8'h00, 8'hFF, 8'h00, 8'h01}, 1'b0, NO_EDGE},
        '{'{8'h00, 8'hFF, 8'h00, 8'h02}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'hFF, 8'h00, 8'h04}, 1'b0, NO_EDGE},
        '{'{8'h00, 8'h00, 8'h00, 8'h08}, 1'b0, NO_EDGE},
        '{'{8'h00, 8'h00, 8'hFF, 8'h10}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'h00, 8'h00, 8'h20}, 1'b0, NO_EDGE},
        '{'{8'h00, 8'h00, 8'h00, 8'h40}, 1'b0, NO_EDGE},
        '{'{8'h00, 8'h00, 8'h00, 8'h80}, 1'b0, NO_EDGE},
        '{'{8'hFF, 8'h00, 8'h00, 8'hFF}, 1'b1,
          '{8'd255, 8'd255, 8'd0, 8'hFF, 11'd1, 11'd1, 1'b1}}
    };

    logic                           clk;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [sem_pkg::CFG_W-1:0]      cfg_data      = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sem_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [sem_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    sobel_edge_magnitude_rgb #(
        .MAX_WIDTH (LINE_MAX),
        .MAX_HEIGHT(FRAME_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // edge model state
    logic [sem_pkg::CFG_W-1:0] width_reg  = sem_pkg::CFG_W'(sem_pkg::IMAGE_WIDTH_RST);
    logic [sem_pkg::CFG_W-1:0] height_reg = sem_pkg::CFG_W'(sem_pkg::IMAGE_HEIGHT_RST);
    sem_pkg::pix_t             older_line [LINE_MAX];
    sem_pkg::pix_t             newer_line [LINE_MAX];
    sem_pkg::pix_t             window_cols [6] = '{default: '0};
    sem_pkg::pix_t             hood [3][3];
    int                        col_pos = 0;
    int                        row_pos = 0;

    edge_result_t     pending_edges [$];
    int               mismatches   = 0;
    int               src_gap_pct  = IDLE_PCT;
    int               sink_gap_pct = IDLE_PCT;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic int clamp_size(input logic [sem_pkg::CFG_W-1:0] value, input int hi);
        int v;
        v = int'(value);
        if (v < sem_pkg::MIN_SIZE)
            return sem_pkg::MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // floor of the gradient magnitude over the current 3x3 neighborhood
    function automatic sem_pkg::chan_t edge_strength(input int ch);
        int p [3][3];
        int r, c, gx, gy, ax, ay, sq, root, trial, b;
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                p[r][c] = int'(hood[r][c][ch]);
        gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        gy = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        if (ax > 255)
            ax = 255;
        if (ay > 255)
            ay = 255;
        sq = ax * ax + ay * ay;
        root = 0;
        for (b = 128; b > 0; b = b >> 1)
        begin
            trial = root | b;
            if (trial * trial <= sq)
                root = trial;
        end
        return sem_pkg::chan_t'(root);
    endfunction

    task automatic predict_pixel(input pixel_t px, output bit hit, output edge_result_t res);
        int            w, h, c, r, i;
        sem_pkg::pix_t cur, top, mid;
        w = clamp_size(width_reg, LINE_MAX);
        h = clamp_size(height_reg, FRAME_MAX);
        c = col_pos % LINE_MAX;
        r = row_pos;
        cur[0] = px.red;
        cur[1] = px.green;
        cur[2] = px.blue;
        top = older_line[c];
        mid = newer_line[c];
        older_line[c] = mid;
        newer_line[c] = cur;
        for (i = 0; i < 3; i++)
        begin
            hood[i][0] = window_cols[i];
            hood[i][1] = window_cols[3 + i];
        end
        hood[0][2] = top;
        hood[1][2] = mid;
        hood[2][2] = cur;
        hit = (c >= 2 && r >= 2 && c < w && r < h);
        res = '0;
        if (hit)
        begin
            res.red_mag   = edge_strength(0);
            res.green_mag = edge_strength(1);
            res.blue_mag  = edge_strength(2);
            res.alpha     = px.alpha;
            res.column    = sem_pkg::POS_W'(c - 1);
            res.row       = sem_pkg::POS_W'(r - 1);
            res.eof       = (c - 1 == w - 2) && (r - 1 == h - 2);
        end
        for (i = 0; i < 3; i++)
        begin
            window_cols[i]     = window_cols[3 + i];
            window_cols[3 + i] = hood[i][2];
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    function automatic pixel_t make_pixel(input pattern_t mode, input sem_pkg::chan_t base);
        pixel_t   px;
        pattern_t pick;
        pick = mode;
        if (mode == PAT_MIXED)
            pick = pattern_t'($urandom_range(PAT_NOISE, PAT_RAILS));
        px = $urandom;
        case (pick)
            PAT_SMOOTH:
            begin
                px.red   = base + sem_pkg::chan_t'($urandom_range(0, 12));
                px.green = base + sem_pkg::chan_t'($urandom_range(0, 12));
                px.blue  = base + sem_pkg::chan_t'($urandom_range(0, 12));
            end
            PAT_RAILS:
            begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
                ;
        endcase
        return px;
    endfunction

    task automatic write_reg(input sem_pkg::cfg_reg_t idx,
                             input logic [sem_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sem_pkg::REG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(posedge clk);
    endtask

    task automatic feed_pixel(input pixel_t px, input logic typed, input edge_result_t want);
        bit           hit;
        edge_result_t res;
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.alpha, px.blue, px.green, px.red};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_pixel(px, hit, res);
        if (typed)
            pending_edges.push_back(want);
        else if (hit)
            pending_edges.push_back(res);
    endtask

    // drain every expected beat, then let border pixels clear the pipeline
    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frame(input logic [sem_pkg::CFG_W-1:0] w_val,
                             input logic [sem_pkg::CFG_W-1:0] h_val,
                             output int pixels);
        int             i;
        pattern_t       mode;
        sem_pkg::chan_t base;
        settle_pipeline();
        write_reg(sem_pkg::REG_IMAGE_WIDTH, w_val);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, h_val);
        pixels = clamp_size(w_val, LINE_MAX) * clamp_size(h_val, FRAME_MAX);
        mode   = pattern_t'($urandom_range(PAT_NOISE, PAT_MIXED));
        base   = sem_pkg::chan_t'($urandom_range(0, 243));
        for (i = 0; i < pixels; i++)
            feed_pixel(make_pixel(mode, base), 1'b0, NO_EDGE);
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : watch_results
        edge_result_t want;
        edge_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.red_mag   = m_axis_tdata[7:0];
            got.green_mag = m_axis_tdata[15:8];
            got.blue_mag  = m_axis_tdata[23:16];
            got.alpha     = m_axis_tdata[31:24];
            got.column    = m_axis_tdata[42:32];
            got.row       = m_axis_tdata[53:43];
            got.eof       = m_axis_tlast;
            if (pending_edges.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time,
                         got);
                mismatches++;
            end
            else
            begin
                want = pending_edges.pop_front();
                check_field("red_magnitude", want.red_mag, got.red_mag);
                check_field("green_magnitude", want.green_mag, got.green_mag);
                check_field("blue_magnitude", want.blue_mag, got.blue_mag);
                check_field("alpha_out", want.alpha, got.alpha);
                check_field("out_column", want.column, got.column);
                check_field("out_row", want.row, got.row);
                check_field("end_of_frame", want.eof, got.eof);
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int pixels;
        int item_count;
        item_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        settle_pipeline();
        write_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::CFG_W'(sem_pkg::MIN_SIZE));
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::CFG_W'(sem_pkg::MIN_SIZE));
        for (i = 0; i < DIRECTED_COUNT; i++)
            feed_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        item_count += DIRECTED_COUNT;

        // sizes below the minimum clamp up
        run_frame(12'd0, 12'd1, pixels);
        item_count += pixels;
        run_frame(12'd2, 12'd2, pixels);
        item_count += pixels;
        run_frame(12'd5, 12'd3, pixels);
        item_count += pixels;
        // long frame with no idling on either side
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        run_frame(12'd100, 12'd3, pixels);
        item_count += pixels;
        src_gap_pct  = IDLE_PCT;
        sink_gap_pct = IDLE_PCT;
        run_frame(12'd3, 12'd60, pixels);
        item_count += pixels;

        while (item_count < ITEM_TARGET)
        begin
            run_frame(sem_pkg::CFG_W'($urandom_range(3, 40)),
                      sem_pkg::CFG_W'($urandom_range(3, 10)), pixels);
            item_count += pixels;
        end

        settle_pipeline();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
